// ===== rtl/core/itod_pkg.sv =====
// shared types and constants for the decimal ascii converter
package itod_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_EMIT
	} state_t;

	localparam logic [5:0] ASCII_ZERO  = 6'd48;
	localparam logic [5:0] ASCII_MINUS = 6'd45;
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;
	localparam logic [3:0] BCD_MAX     = 4'd9;

endpackage

// ===== rtl/core/itod_bcd_step.sv =====
// one shift-add-3 step over a packed bcd register
module itod_bcd_step
	import itod_pkg::*;
#(
	parameter int NDIG = 10
) (
	input  logic [NDIG*4-1:0] bcd,
	input  logic              bit_in,
	output logic [NDIG*4-1:0] bcd_next
);

	logic [NDIG*4-1:0] adj;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd[4*i +: 4] >= BCD_ADJ_MIN) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + BCD_ADJ;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_next = {adj[NDIG*4-2:0], bit_in};

endmodule

// ===== rtl/core/integer_to_decimal_ascii_core.sv =====
// binary word to decimal ascii text converter, top level
//
// Input channel s_*: one item per number. s_tdata carries the raw word, s_tuser
// the mode (0 unsigned, 1 signed two's complement). Only the low VALUE_BITS
// bits of the word are used. s_tready is high only while the block is idle.
// Output channel m_*: one item per ascii character, most significant first,
// with a leading '-' for negative signed words; m_tlast marks the final digit.
// Zero gives the single character '0'.
// Steps per item: accept in idle, then shift-add-3 through the single
// bcd step unit (one input bit a cycle), then a trim state that drops
// leading zero digits (up to NDIG-1), then one character per cycle when
// the receiver keeps up.
// The result sits in an output register; when the receiver stalls the
// sequencer waits and the character holds until taken.
// Reset (arst_n low) returns the sequencer to idle and drops m_tvalid.
module integer_to_decimal_ascii_core
	import itod_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
	output logic        m_tlast    // last
);

	localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * 4;
	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam int REM_W = $clog2(NDIG);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
	localparam logic [REM_W-1:0] REM_LAST = REM_W'(NDIG - 1);

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] value_ext;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_step;
	logic [CNT_W-1:0]      cnt_q;
	logic [REM_W-1:0]      rem_q;
	logic                  neg_q;
	logic [5:0]            char_q;
	logic                  last_q;
	logic                  m_tvalid_q;

	logic                  in_take;
	logic                  out_free;
	logic                  out_load;
	logic [3:0]            top_digit;
	logic                  bcd_ok;

	generate
		if (VALUE_BITS <= 32) begin : g_narrow
			assign value_ext = s_tdata[VALUE_BITS-1:0];
		end else begin : g_wide
			assign value_ext = {{(VALUE_BITS-32){1'b0}}, s_tdata};
		end
	endgenerate

	itod_bcd_step #(
		.NDIG(NDIG)
	) u_step (
		.bcd     (bcd_q),
		.bit_in  (mag_q[VALUE_BITS-1]),
		.bcd_next(bcd_step)
	);

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == '0) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				// drop leading zero digits, keep at least one
				if (rem_q == '0 || top_digit != '0) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (!neg_q && rem_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					neg_q <= s_tuser[0] && value_ext[VALUE_BITS-1];
					if (s_tuser[0] && value_ext[VALUE_BITS-1]) begin
						mag_q <= ~value_ext + 1'b1;
					end else begin
						mag_q <= value_ext;
					end
					bcd_q <= '0;
					cnt_q <= CNT_LAST;
				end
			end
			ST_CONV: begin
				bcd_q <= bcd_step;
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				rem_q <= REM_LAST;
			end
			ST_TRIM: begin
				if (rem_q != '0 && top_digit == '0) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					rem_q <= rem_q - 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					if (neg_q) begin
						char_q <= ASCII_MINUS;
						last_q <= 1'b0;
						neg_q  <= 1'b0;
					end else begin
						char_q <= ASCII_ZERO + {2'b00, top_digit};
						last_q <= (rem_q == '0);
						bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
						if (rem_q != '0) begin
							rem_q <= rem_q - 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, char_q};
	assign m_tlast  = last_q;

	always_comb begin
		bcd_ok = 1'b1;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] > BCD_MAX) begin
				bcd_ok = 1'b0;
			end
		end
	end

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == ST_CONV)
		else $error("accepted item did not start conversion");

	a_bcd_digits_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIM || state_q == ST_EMIT) |-> bcd_ok)
		else $error("bcd digit above nine after conversion");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] == ASCII_MINUS
			|| (m_tdata[5:0] >= ASCII_ZERO && m_tdata[5:0] <= ASCII_ZERO + 6'd9)))
		else $error("output character is not a digit or minus");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !neg_q && rem_q == '0) |=> (state_q == ST_IDLE && m_tlast))
		else $error("final character did not end the item");

endmodule
